### rtl/ambisonic_diffuse_order_upmix_unit_macros.svh
// Assertion macros shared by the ambisonic upmix RTL.
`ifndef AMBISONIC_DIFFUSE_ORDER_UPMIX_UNIT_MACROS_SVH
`define AMBISONIC_DIFFUSE_ORDER_UPMIX_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ADOU_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Condition in one cycle that implies another in the same cycle.
`define ADOU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define ADOU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/adou_pkg.sv
// Types and constants shared by the ambisonic diffuse order upmix modules.
package adou_pkg;

    localparam int NUM_IN_FIELDS   = 3;
    localparam int NUM_OUT_FIELDS  = 11;

    localparam int DELAY_BITS      = 11;
    localparam int ORDER_BITS      = 3;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 11;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET     = 11'd480;
    localparam logic [ORDER_BITS-1:0] MAX_ORDER_RESET = 3'd3;

    localparam int COEF_BITS  = 18;
    localparam int COEF_FRAC  = 17;
    localparam logic signed [COEF_BITS-1:0] COEF_Q17 = 18'sd92682;
    localparam int ROUND_HALF = 1 << (COEF_FRAC - 1);

    localparam int FIRST_ORDER = 2;
    localparam int LAST_ORDER  = 5;
    localparam int NUM_STAGES  = LAST_ORDER - FIRST_ORDER + 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DELAY_SAMPLES = 8'd0,
        REG_MAX_ORDER     = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic advance;
        logic valid;
        logic order_on;
    } rot_ctrl_t;

endpackage

### rtl/ambisonic_diffuse_order_upmix_unit.sv
// Diffuse first-to-higher-order ambisonic upmix with x and y comb delay lines.
//
// Input words on s_tvalid/s_tready carry one (w, x, y) sample triple. Each accepted
// word produces exactly one result word on m_tvalid/m_tready carrying w, x and y
// unchanged plus the order 2 to 5 components; orders above max_order are zero.
// Registers are written on the cfg channel (index 0 delay_samples, index 1
// max_order), which is always ready; write them only while no word is in flight.
// Results pass stage 1, comb, rotation and output registers. The block takes
// one word per cycle: per word the delay memories do one write at the write
// position and one registered read at the delayed position, and the four order
// rotations sit in a pipeline of their own, one multiplier set per order.
// After reset the write position and a fill count are zero; history entries not
// yet written read as zero, so no clearing pass is needed and words are taken at
// once. When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops until the result word is taken.
`include "ambisonic_diffuse_order_upmix_unit_macros.svh"

module ambisonic_diffuse_order_upmix_unit #(
    parameter int DELAY_DEPTH = 2048,
    parameter int SAMPLE_BITS = 24,
    parameter int ORDER_LIMIT = 5
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // Fields from bit 0 up: w_in, x_in, y_in.
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // Fields from bit 0 up: w_out, x_out, y_out, order2_neg, order2_pos,
    // order3_neg, order3_pos, order4_neg, order4_pos, order5_neg, order5_pos.
    output logic [((11*SAMPLE_BITS+7)/8)*8-1:0]           m_tdata,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [adou_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [adou_pkg::CFG_DATA_BITS-1:0]            cfg_data
);
    import adou_pkg::*;

    localparam int AW          = $clog2(DELAY_DEPTH);
    localparam int DCW         = (AW > DELAY_BITS) ? AW : DELAY_BITS;
    localparam int ROT_BITS    = SAMPLE_BITS + 5;
    localparam int PAY_BITS    = NUM_OUT_FIELDS * SAMPLE_BITS;
    localparam int M_TDATA_BITS = ((11 * SAMPLE_BITS + 7) / 8) * 8;

    // Configuration registers.
    logic [DELAY_BITS-1:0] delay_reg;
    logic [ORDER_BITS-1:0] max_order_reg;

    // Write position and fill count of the delay lines.
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic [AW:0]   fill_reg;
    logic [AW:0]   fill_next;

    logic [DCW-1:0] d_wide;
    logic [AW-1:0]  d_eff;
    logic [AW:0]    rd_sum;
    logic [AW-1:0]  rd_addr;
    logic           sel_fwd;
    logic           sel_zero;

    logic advance;
    logic s_fire;
    logic [ORDER_BITS-1:0] order_lim;

    logic signed [SAMPLE_BITS-1:0] x_mem [DELAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] y_mem [DELAY_DEPTH];

    // Stage 1: registered memory read and input word.
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_w_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic signed [SAMPLE_BITS-1:0] s1_y_reg;
    logic signed [SAMPLE_BITS-1:0] xd_reg;
    logic signed [SAMPLE_BITS-1:0] yd_reg;
    logic                          s1_fwd_reg;
    logic                          s1_zero_reg;
    logic signed [SAMPLE_BITS-1:0] xd_eff;
    logic signed [SAMPLE_BITS-1:0] yd_eff;

    // Stage 2: comb halves.
    logic                       s2_valid_reg;
    logic signed [ROT_BITS-1:0] s2_x1_reg;
    logic signed [ROT_BITS-1:0] s2_y1_reg;
    logic signed [ROT_BITS-1:0] s2_x2_reg;
    logic signed [ROT_BITS-1:0] s2_y2_reg;
    logic [PAY_BITS-1:0]        s2_payload_reg;
    logic [PAY_BITS-1:0]        s1_payload;

    // Rotation chain, entry 0 is the comb stage.
    logic                       st_valid   [NUM_STAGES+1];
    logic signed [ROT_BITS-1:0] st_x1      [NUM_STAGES+1];
    logic signed [ROT_BITS-1:0] st_y1      [NUM_STAGES+1];
    logic signed [ROT_BITS-1:0] st_x2      [NUM_STAGES+1];
    logic signed [ROT_BITS-1:0] st_y2      [NUM_STAGES+1];
    logic [PAY_BITS-1:0]        st_payload [NUM_STAGES+1];
    rot_ctrl_t                  st_ctrl    [NUM_STAGES];

    logic                m_tvalid_reg;
    logic [PAY_BITS-1:0] m_payload_reg;

    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = advance;
    assign s_fire    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg     <= DELAY_RESET;
            max_order_reg <= MAX_ORDER_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DELAY_SAMPLES: delay_reg     <= cfg_data[DELAY_BITS-1:0];
                REG_MAX_ORDER:     max_order_reg <= cfg_data[ORDER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        d_wide  = DCW'(delay_reg);
        d_eff   = (d_wide > DCW'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1) : AW'(d_wide);
        rd_sum  = {1'b0, wp_reg} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_eff};
        rd_addr = (rd_sum >= (AW+1)'(DELAY_DEPTH)) ? AW'(rd_sum - (AW+1)'(DELAY_DEPTH))
                                                   : AW'(rd_sum);
        sel_fwd  = (d_eff == '0);
        sel_zero = ({1'b0, d_eff} > fill_reg);
        wp_next  = ({1'b0, wp_reg} == (AW+1)'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        fill_next = (fill_reg == (AW+1)'(DELAY_DEPTH)) ? fill_reg : fill_reg + (AW+1)'(1);
        order_lim = (max_order_reg > ORDER_BITS'(ORDER_LIMIT)) ? ORDER_BITS'(ORDER_LIMIT)
                                                               : max_order_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (s_fire) begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_mem[wp_reg] <= s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
            y_mem[wp_reg] <= s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
            xd_reg        <= x_mem[rd_addr];
            yd_reg        <= y_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_w_reg    <= s_tdata[0 +: SAMPLE_BITS];
            s1_x_reg    <= s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
            s1_y_reg    <= s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
            s1_fwd_reg  <= sel_fwd;
            s1_zero_reg <= sel_zero;
        end
    end

    always_comb begin
        if (s1_fwd_reg) begin
            xd_eff = s1_x_reg;
            yd_eff = s1_y_reg;
        end else if (s1_zero_reg) begin
            xd_eff = '0;
            yd_eff = '0;
        end else begin
            xd_eff = xd_reg;
            yd_eff = yd_reg;
        end
        s1_payload = '0;
        s1_payload[0 +: SAMPLE_BITS]             = s1_w_reg;
        s1_payload[SAMPLE_BITS +: SAMPLE_BITS]   = s1_x_reg;
        s1_payload[2*SAMPLE_BITS +: SAMPLE_BITS] = s1_y_reg;
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            s2_x1_reg      <= ROT_BITS'(s1_x_reg) + ROT_BITS'(xd_eff);
            s2_x2_reg      <= ROT_BITS'(s1_x_reg) - ROT_BITS'(xd_eff);
            s2_y1_reg      <= ROT_BITS'(s1_y_reg) + ROT_BITS'(yd_eff);
            s2_y2_reg      <= ROT_BITS'(s1_y_reg) - ROT_BITS'(yd_eff);
            s2_payload_reg <= s1_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            m_tvalid_reg <= st_valid[NUM_STAGES];
        end
    end

    assign st_valid[0]   = s2_valid_reg;
    assign st_x1[0]      = s2_x1_reg;
    assign st_y1[0]      = s2_y1_reg;
    assign st_x2[0]      = s2_x2_reg;
    assign st_y2[0]      = s2_y2_reg;
    assign st_payload[0] = s2_payload_reg;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_order
        assign st_ctrl[k].advance  = advance;
        assign st_ctrl[k].valid    = st_valid[k];
        assign st_ctrl[k].order_on = (ORDER_BITS'(k + FIRST_ORDER) <= order_lim);

        adou_rot_stage #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ROT_BITS    (ROT_BITS),
            .ORDER       (k + FIRST_ORDER)
        ) u_rot (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (st_ctrl[k]),
            .in_x1       (st_x1[k]),
            .in_y1       (st_y1[k]),
            .in_x2       (st_x2[k]),
            .in_y2       (st_y2[k]),
            .in_payload  (st_payload[k]),
            .out_valid   (st_valid[k+1]),
            .out_x1      (st_x1[k+1]),
            .out_y1      (st_y1[k+1]),
            .out_x2      (st_x2[k+1]),
            .out_y2      (st_y2[k+1]),
            .out_payload (st_payload[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (advance && st_valid[NUM_STAGES]) begin
            m_payload_reg <= st_payload[NUM_STAGES];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_payload_reg);

    `ADOU_ASSERT_HOLDS(a_fill_bound, fill_reg <= (AW+1)'(DELAY_DEPTH), "fill count beyond depth")
    `ADOU_ASSERT_NEXT(a_idle_position, !s_fire, $stable(wp_reg) && $stable(fill_reg),
        "write position moved without an accepted word")
    `ADOU_ASSERT_NEXT(a_stall_holds_read, !advance,
        $stable(xd_reg) && $stable(yd_reg) && $stable(s1_valid_reg),
        "delayed read data lost during a stall")
    `ADOU_ASSERT_SAME(a_fwd_not_zero, s1_valid_reg && s1_fwd_reg, !s1_zero_reg,
        "zero delay marked as unwritten history")

endmodule

### rtl/adou_rot_stage.sv
// One order of the upmix: 45 degree rotation of both comb pairs and saturated output.
module adou_rot_stage #(
    parameter int SAMPLE_BITS = 24,
    parameter int ROT_BITS    = 29,
    parameter int ORDER       = 2
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  adou_pkg::rot_ctrl_t                                ctrl,
    input  logic signed [ROT_BITS-1:0]                         in_x1,
    input  logic signed [ROT_BITS-1:0]                         in_y1,
    input  logic signed [ROT_BITS-1:0]                         in_x2,
    input  logic signed [ROT_BITS-1:0]                         in_y2,
    input  logic [adou_pkg::NUM_OUT_FIELDS*SAMPLE_BITS-1:0]    in_payload,
    output logic                                               out_valid,
    output logic signed [ROT_BITS-1:0]                         out_x1,
    output logic signed [ROT_BITS-1:0]                         out_y1,
    output logic signed [ROT_BITS-1:0]                         out_x2,
    output logic signed [ROT_BITS-1:0]                         out_y2,
    output logic [adou_pkg::NUM_OUT_FIELDS*SAMPLE_BITS-1:0]    out_payload
);
    import adou_pkg::*;

    localparam int PAY_BITS  = NUM_OUT_FIELDS * SAMPLE_BITS;
    localparam int PROD_BITS = ROT_BITS + COEF_BITS;
    localparam int NEG_LSB   = (2 * ORDER - 1) * SAMPLE_BITS;
    localparam int POS_LSB   = 2 * ORDER * SAMPLE_BITS;
    localparam logic signed [ROT_BITS-1:0] SAT_HI =
        ROT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ROT_BITS-1:0] SAT_LO = -SAT_HI - ROT_BITS'(1);

    logic                       valid_reg;
    logic signed [ROT_BITS-1:0] x1_reg;
    logic signed [ROT_BITS-1:0] y1_reg;
    logic signed [ROT_BITS-1:0] x2_reg;
    logic signed [ROT_BITS-1:0] y2_reg;
    logic [PAY_BITS-1:0]        payload_reg;

    function automatic logic signed [ROT_BITS-1:0] rot_q(input logic signed [ROT_BITS-1:0] a);
        logic signed [PROD_BITS-1:0] p;
        p = PROD_BITS'(a) * PROD_BITS'(COEF_Q17);
        p = p + PROD_BITS'(ROUND_HALF);
        return ROT_BITS'(p >>> COEF_FRAC);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_q(input logic signed [ROT_BITS-1:0] s);
        logic signed [ROT_BITS-1:0] v;
        v = (s + ROT_BITS'(1)) >>> 1;
        if (v > SAT_HI) begin
            v = SAT_HI;
        end else if (v < SAT_LO) begin
            v = SAT_LO;
        end
        return SAMPLE_BITS'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance && ctrl.valid) begin
            x1_reg      <= rot_q(in_x1 - in_y1);
            y1_reg      <= rot_q(in_x1 + in_y1);
            x2_reg      <= rot_q(in_x2 + in_y2);
            y2_reg      <= rot_q(in_x2 - in_y2);
            payload_reg <= in_payload;
        end
    end

    always_comb begin
        out_payload = payload_reg;
        out_payload[NEG_LSB +: SAMPLE_BITS] = ctrl.order_on ? sat_q(x1_reg + x2_reg) : '0;
        out_payload[POS_LSB +: SAMPLE_BITS] = ctrl.order_on ? sat_q(y1_reg + y2_reg) : '0;
    end

    assign out_valid = valid_reg;
    assign out_x1    = x1_reg;
    assign out_y1    = y1_reg;
    assign out_x2    = x2_reg;
    assign out_y2    = y2_reg;

endmodule
